// ===== hdl/vt_pkg.sv =====
package vt_pkg;

   // Q16.16 word format
   localparam int WORD_BITS    = 32;
   localparam int FRAC_BITS    = 16;
   localparam int LANES        = 4;
   localparam int PROD_BITS    = 2 * WORD_BITS;
   localparam int ACC_BITS     = PROD_BITS + 2;
   localparam int NUM_BITS     = WORD_BITS + FRAC_BITS;
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS);

   // 1.0 in the word format, used as w for points
   localparam logic [WORD_BITS-1:0] ONE_Q = WORD_BITS'(64'd1 << FRAC_BITS);

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_VECTOR = 2'd1,
      REQ_POINT  = 2'd2,
      REQ_UNUSED = 2'd3
   } vt_req_kind_type;

   typedef logic [LANES-1:0][WORD_BITS-1:0] vt_quad_type;

   typedef struct packed {
      logic [1:0]                  req_type;
      logic [1:0]                  row_index;
      logic signed [WORD_BITS-1:0] in_x;
      logic signed [WORD_BITS-1:0] in_y;
      logic signed [WORD_BITS-1:0] in_z;
      logic signed [WORD_BITS-1:0] in_w;
   } vt_req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] out_x;
      logic signed [WORD_BITS-1:0] out_y;
      logic signed [WORD_BITS-1:0] out_z;
      logic signed [WORD_BITS-1:0] out_w;
      logic                        divide_by_zero;
      logic                        overflow;
   } vt_rsp_type;

   // sequencer to multiply-accumulate lanes
   typedef struct packed {
      logic       clear;
      logic       mul_en;
      logic [1:0] col;
      logic       acc_en;
   } vt_lane_ctrl_type;

endpackage

// ===== hdl/vertex_transform_4x4.sv =====
// Homogeneous 4x4 transform in signed Q16.16. A load item writes one matrix
// row and gives no result; a vector item multiplies (x,y,z,w) by the matrix;
// a point item uses w = 1.0 and then divides x, y and z by the resulting w,
// truncating toward zero (a zero w gives zero x, y, z and sets
// divide_by_zero). Row sums are exact, shifted back to Q16.16 and saturated;
// any saturation sets overflow. One item is worked on at a time. A vector
// item goes from transfer to the result register through the MAC steps,
// in which four row lanes each share one 32x32 multiplier over the four
// columns, then the drain, evaluate and hand-over steps. A point item adds
// a divide step, set by the three divider lanes that produce one quotient
// bit per cycle over 48 bits. A finished result waits in the output register
// while the next item is taken.
module vertex_transform_4x4 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  vt_pkg::vt_req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output vt_pkg::vt_rsp_type rsp_data
);
   import vt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EVAL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 point_ff, point_in;
   logic                 acc_pend_ff, acc_pend_in;
   vt_quad_type          vec_ff, vec_in;
   vt_quad_type          res_ff, res_in;
   logic                 ov_ff, ov_in;
   logic                 dz_ff, dz_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   vt_rsp_type           rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 is_load, is_xform;
   vt_lane_ctrl_type     lane_ctrl;
   vt_quad_type          load_row;
   logic [LANES-1:0]     load_en;
   logic [WORD_BITS-1:0] lane_res [LANES];
   logic [LANES-1:0]     lane_sat;
   logic                 div_start;
   logic [2:0]           div_done;
   logic [WORD_BITS-1:0] div_q [3];
   logic [2:0]           div_sat;
   logic                 out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_load   = (req_data.req_type == REQ_LOAD);
   assign is_xform  = (req_data.req_type == REQ_VECTOR)
                   || (req_data.req_type == REQ_POINT);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign load_row[0] = req_data.in_x;
   assign load_row[1] = req_data.in_y;
   assign load_row[2] = req_data.in_z;
   assign load_row[3] = req_data.in_w;

   always_comb begin
      lane_ctrl.clear  = accept && is_xform;
      lane_ctrl.mul_en = (state_ff == ST_MAC);
      lane_ctrl.col    = cnt_ff;
      lane_ctrl.acc_en = acc_pend_ff;
   end

   // one multiply-accumulate lane per matrix row
   for (genvar g = 0; g < LANES; g++) begin : g_row
      assign load_en[g] = accept && is_load && (req_data.row_index == 2'(g));

      vt_mac_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl),
         .load_en  (load_en[g]),
         .load_row (load_row),
         .vec      (vec_ff),
         .result   (lane_res[g]),
         .sat      (lane_sat[g])
      );
   end

   // one divider lane per x, y, z
   for (genvar g = 0; g < 3; g++) begin : g_div
      vt_div_lane u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (lane_res[g]),
         .divisor  (lane_res[3]),
         .done     (div_done[g]),
         .quotient (div_q[g]),
         .sat      (div_sat[g])
      );
   end

   // sequence an item and merge the lane results
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      point_in     = point_ff;
      acc_pend_in  = (state_ff == ST_MAC);
      vec_in       = vec_ff;
      res_in       = res_ff;
      ov_in        = ov_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_xform) begin
               point_in  = (req_data.req_type == REQ_POINT);
               vec_in[0] = req_data.in_x;
               vec_in[1] = req_data.in_y;
               vec_in[2] = req_data.in_z;
               vec_in[3] = (req_data.req_type == REQ_POINT) ? ONE_Q : req_data.in_w;
               cnt_in    = '0;
               state_in  = ST_MAC;
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'(LANES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            for (int i = 0; i < LANES; i++) begin
               res_in[i] = lane_res[i];
            end
            ov_in = |lane_sat;
            dz_in = point_ff && (lane_res[3] == '0);
            if (point_ff && (lane_res[3] == '0)) begin
               res_in[0] = '0;
               res_in[1] = '0;
               res_in[2] = '0;
               state_in  = ST_DONE;
            end else if (point_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (&div_done) begin
               for (int i = 0; i < 3; i++) begin
                  res_in[i] = div_q[i];
               end
               ov_in    = ov_ff || (|div_sat);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.out_x          = res_ff[0];
               rsp_data_in.out_y          = res_ff[1];
               rsp_data_in.out_z          = res_ff[2];
               rsp_data_in.out_w          = res_ff[3];
               rsp_data_in.divide_by_zero = dz_ff;
               rsp_data_in.overflow       = ov_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         acc_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_pend_ff  <= acc_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      point_ff    <= point_in;
      vec_ff      <= vec_in;
      res_ff      <= res_in;
      ov_ff       <= ov_in;
      dz_ff       <= dz_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/vt_mac_lane.sv =====
module vt_mac_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  vt_pkg::vt_lane_ctrl_type     ctrl,
   input  logic                         load_en,
   input  vt_pkg::vt_quad_type          load_row,
   input  vt_pkg::vt_quad_type          vec,
   output logic [vt_pkg::WORD_BITS-1:0] result,
   output logic                         sat
);
   import vt_pkg::*;

   localparam int TOP = FRAC_BITS + WORD_BITS - 1;

   logic [WORD_BITS-1:0]        row_ff [LANES];
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [WORD_BITS-1:0] a_sel, b_sel;
   logic [ACC_BITS-1-TOP:0]     upper;
   logic                        in_range;

   // select the column operands and multiply
   always_comb begin
      a_sel   = row_ff[ctrl.col];
      b_sel   = vec[ctrl.col];
      prod_in = a_sel * b_sel;
   end

   // accumulate the exact products
   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // hold the matrix row; a load writes all four elements
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            row_ff[i] <= '0;
         end
      end else if (load_en) begin
         for (int i = 0; i < LANES; i++) begin
            row_ff[i] <= load_row[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   // drop the fraction bits and saturate to one word
   always_comb begin
      upper    = acc_ff[ACC_BITS-1:TOP];
      in_range = (&upper) || !(|upper);
      sat      = !in_range;
      if (in_range) begin
         result = acc_ff[TOP:FRAC_BITS];
      end else if (acc_ff[ACC_BITS-1]) begin
         result = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         result = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
   end

endmodule

// ===== hdl/vt_div_lane.sv =====
module vt_div_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [vt_pkg::WORD_BITS-1:0] dividend,
   input  logic [vt_pkg::WORD_BITS-1:0] divisor,
   output logic                         done,
   output logic [vt_pkg::WORD_BITS-1:0] quotient,
   output logic                         sat
);
   import vt_pkg::*;

   localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(NUM_BITS - 1);

   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic [NUM_BITS-1:0]     num_ff, num_in;
   logic [WORD_BITS-1:0]    rem_ff, rem_in;
   logic [WORD_BITS-1:0]    den_ff, den_in;
   logic [WORD_BITS-1:0]    mag_c, mag_w;
   logic [WORD_BITS:0]      trial;
   logic                    qbit;

   always_comb begin
      mag_c = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
      mag_w = divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
      trial = {rem_ff, num_ff[NUM_BITS-1]};
      qbit  = (trial >= {1'b0, den_ff});
   end

   // restoring division, one quotient bit per cycle
   always_comb begin
      run_in  = run_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in  = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         neg_in  = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
         num_in  = {mag_c, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = mag_w;
      end else if (run_ff) begin
         num_in = {num_ff[NUM_BITS-2:0], qbit};
         rem_in = qbit ? WORD_BITS'(trial - {1'b0, den_ff}) : trial[WORD_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // apply the sign and saturate the quotient
   always_comb begin
      done = done_ff;
      if (neg_ff) begin
         sat = (|num_ff[NUM_BITS-1:WORD_BITS])
            || (num_ff[WORD_BITS-1] && (|num_ff[WORD_BITS-2:0]));
         quotient = sat ? {1'b1, {(WORD_BITS-1){1'b0}}}
                        : (~num_ff[WORD_BITS-1:0] + 1'b1);
      end else begin
         sat = |num_ff[NUM_BITS-1:WORD_BITS-1];
         quotient = sat ? {1'b0, {(WORD_BITS-1){1'b1}}} : num_ff[WORD_BITS-1:0];
      end
   end

endmodule

// ===== hdl/vt_checker.sv =====
module vt_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  vt_pkg::vt_req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  vt_pkg::vt_rsp_type rsp_data
);
   import vt_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // a row load never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.req_type == REQ_LOAD) && !rsp_valid
      |=> !rsp_valid)
      else $error("result appeared after a row load");

   // a transform occupies the block for the next cycle
   a_xform_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
      && ((req_data.req_type == REQ_VECTOR) || (req_data.req_type == REQ_POINT))
      |=> req_stall)
      else $error("transform transfer not followed by busy");

   // a zero-w point yields zero components
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero
      |-> (rsp_data.out_x == '0) && (rsp_data.out_y == '0)
       && (rsp_data.out_z == '0) && (rsp_data.out_w == '0))
      else $error("divide by zero result carries nonzero components");

   // no result straight out of reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind vertex_transform_4x4 vt_checker u_vt_checker (.*);
